// ----- rtl/hacr_pkg.sv -----
// Shared types, constants and colour lookup for the hi-res artifact colour renderer.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package hacr_pkg;

    localparam int PIX_PER_BYTE = 7;
    localparam int RGB_W        = 24;

    // Descriptor queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Colour class codes within one palette half
    localparam logic [1:0] CI_BLACK = 2'd0;
    localparam logic [1:0] CI_A     = 2'd1;
    localparam logic [1:0] CI_B     = 2'd2;
    localparam logic [1:0] CI_WHITE = 2'd3;

    // Indexed by {palette bit, colour class}
    localparam logic [RGB_W-1:0] COLOUR_SET [8] = '{
        24'h000000, 24'hD53EF9, 24'h64D440, 24'hFFFFFF,
        24'h000000, 24'h458FF7, 24'hD7762C, 24'hFFFFFF
    };

    // One byte ready to render, with its neighbours and column parity
    typedef struct packed {
        logic [6:0] left_px;
        logic [7:0] cur_byte;
        logic [6:0] right_px;
        logic       parity;
        logic       done;
    } desc_t;

    // Up to two descriptors produced by one accepted beat, in order a then b
    typedef struct packed {
        logic  push_a;
        logic  push_b;
        desc_t desc_a;
        desc_t desc_b;
    } push_t;

    // nbhd = {right, centre, left}
    function automatic logic [RGB_W-1:0] pick_colour(logic [2:0] nbhd, logic j, logic pal);
        logic [1:0] c;
        if (nbhd[1])
        begin
            if (nbhd[0] || nbhd[2])
                c = CI_WHITE;
            else
                c = j ? CI_B : CI_A;
        end
        else
        begin
            if (nbhd[0] && nbhd[2])
                c = j ? CI_A : CI_B;
            else
                c = CI_BLACK;
        end
        return COLOUR_SET[{pal, c}];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hacr_front.sv -----
// Row tracker: holds the pending byte, left neighbour and column parity,
// and turns each accepted beat into zero, one or two render descriptors. Uses hacr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hacr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     video_byte,
    input  wire logic           last_in_row,
    output hacr_pkg::push_t     push
);
    import hacr_pkg::*;

    logic [6:0] left_reg,   left_next;
    logic [7:0] pend_reg,   pend_next;
    logic       pvalid_reg, pvalid_next;
    logic       parity_reg, parity_next;

    logic [6:0] left_mid;
    logic       parity_mid;

    always_comb
    begin
        // pending byte goes out first, with the new byte on its right
        left_mid   = pvalid_reg ? pend_reg[6:0] : left_reg;
        parity_mid = pvalid_reg ? ~parity_reg   : parity_reg;

        push.push_a          = accept && pvalid_reg;
        push.desc_a.left_px  = left_reg;
        push.desc_a.cur_byte = pend_reg;
        push.desc_a.right_px = video_byte[6:0];
        push.desc_a.parity   = parity_reg;
        push.desc_a.done     = 1'b0;

        // row end: new byte closes the row with a blank right neighbour
        push.push_b          = accept && last_in_row;
        push.desc_b.left_px  = left_mid;
        push.desc_b.cur_byte = video_byte;
        push.desc_b.right_px = 7'd0;
        push.desc_b.parity   = parity_mid;
        push.desc_b.done     = 1'b1;

        left_next   = left_reg;
        pend_next   = pend_reg;
        pvalid_next = pvalid_reg;
        parity_next = parity_reg;
        if (accept)
        begin
            if (last_in_row)
            begin
                left_next   = 7'd0;
                pend_next   = 8'd0;
                pvalid_next = 1'b0;
                parity_next = 1'b0;
            end
            else
            begin
                left_next   = left_mid;
                pend_next   = video_byte;
                pvalid_next = 1'b1;
                parity_next = parity_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 7'd0;
            pend_reg   <= 8'd0;
            pvalid_reg <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            pend_reg   <= pend_next;
            pvalid_reg <= pvalid_next;
            parity_reg <= parity_next;
        end
    end

`ifndef SYNTH
    // a row-end beat leaves nothing pending and parity back at zero
    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_in_row |=> !pvalid_reg && !parity_reg && left_reg == 7'd0)
        else $error("row end did not clear row state");

    // a plain beat always leaves a byte pending
    a_byte_pends: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_in_row |=> pvalid_reg && pend_reg == $past(video_byte))
        else $error("accepted byte not held as pending");
`endif

endmodule

`default_nettype wire

// ----- rtl/hacr_queue.sv -----
// Small descriptor queue: two writes and one read per cycle, absorbs the
// extra result of a row-final beat. Uses hacr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hacr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hacr_pkg::push_t push,
    input  wire logic           pop,
    output logic                space,
    output logic                head_valid,
    output hacr_pkg::desc_t     head
);
    import hacr_pkg::*;

    desc_t             entries [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic [QCNT_W-1:0] push_num;
    logic [QPTR_W-1:0] wr_b_addr;

    always_comb
    begin
        push_num    = QCNT_W'(push.push_a) + QCNT_W'(push.push_b);
        wr_b_addr   = wr_ptr_reg + QPTR_W'(push.push_a);
        wr_ptr_next = wr_ptr_reg + push_num[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + push_num - QCNT_W'(pop);
    end

    assign space      = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.push_a)
            entries[wr_ptr_reg] <= push.desc_a;
        if (push.push_b)
            entries[wr_b_addr] <= push.desc_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push_a || push.push_b) |-> count_reg <= QCNT_W'(QDEPTH - 2))
        else $error("descriptor queue written without room");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("descriptor queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("descriptor queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/hacr_render.sv -----
// Pixel renderer: maps the head descriptor to seven RGB pixels and holds
// them in the result register. Uses hacr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hacr_render (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    head_valid,
    input  wire hacr_pkg::desc_t         head,
    output logic                         pop,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic [hacr_pkg::RGB_W-1:0]   pix [hacr_pkg::PIX_PER_BYTE],
    output logic                         row_done
);
    import hacr_pkg::*;

    logic [RGB_W-1:0] pix_reg  [PIX_PER_BYTE];
    logic [RGB_W-1:0] pix_next [PIX_PER_BYTE];
    logic             done_reg;
    logic             valid_reg, valid_next;
    logic [20:0]      stream;

    assign pop = head_valid && (!valid_reg || result_ready);

    always_comb
    begin
        // left neighbour in the low bits, so bit b+7 is pixel b of the byte
        stream = {head.right_px, head.cur_byte[6:0], head.left_px};
        for (int b = 0; b < PIX_PER_BYTE; b++)
            pix_next[b] = pick_colour(stream[b+6 +: 3], head.parity ^ b[0], head.cur_byte[7]);
        valid_next = pop || (valid_reg && !result_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pix_reg  <= pix_next;
            done_reg <= head.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign result_valid = valid_reg;
    assign pix          = pix_reg;
    assign row_done     = done_reg;

endmodule

`default_nettype wire

// ----- rtl/hires_artifact_color_renderer_core.sv -----
// Top level of the hi-res artifact colour renderer: row tracker, descriptor
// queue and pixel renderer. Uses hacr_pkg, hacr_front, hacr_queue, hacr_render.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  --------------------------------
//  item      item_valid / item_ready      video_byte[7:0], last_in_row
//  result    result_valid / result_ready  pixel_0..pixel_6[23:0], row_done
//
// One item beat per cycle, sustained while result_ready stays high. Each beat
// produces zero, one or two result beats; over a row the counts match, and the
// second result of a row-final beat is soaked up by the four-entry descriptor queue.
// A result is written into the queue and then into the pixel register before it
// appears. item_ready falls when fewer than two queue slots are free, so a stalled
// result side backs up into item_ready after a few beats.
// Reset clears the row state, the queue pointers and result_valid.
`timescale 1ns / 1ps
`default_nettype none

module hires_artifact_color_renderer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  video_byte,
    input  wire logic        last_in_row,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [23:0]      pixel_0,
    output logic [23:0]      pixel_1,
    output logic [23:0]      pixel_2,
    output logic [23:0]      pixel_3,
    output logic [23:0]      pixel_4,
    output logic [23:0]      pixel_5,
    output logic [23:0]      pixel_6,
    output logic             row_done
);
    import hacr_pkg::*;

    push_t            push;
    desc_t            head;
    logic             head_valid;
    logic             space;
    logic             pop;
    logic             item_accept;
    logic [RGB_W-1:0] pix [PIX_PER_BYTE];

    // ready depends only on queue occupancy, never on the state of the output
    assign item_ready  = space;
    assign item_accept = item_valid && item_ready;

    hacr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (item_accept),
        .video_byte  (video_byte),
        .last_in_row (last_in_row),
        .push        (push)
    );

    hacr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .space      (space),
        .head_valid (head_valid),
        .head       (head)
    );

    hacr_render u_render (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pix          (pix),
        .row_done     (row_done)
    );

    assign pixel_0 = pix[0];
    assign pixel_1 = pix[1];
    assign pixel_2 = pix[2];
    assign pixel_3 = pix[3];
    assign pixel_4 = pix[4];
    assign pixel_5 = pix[5];
    assign pixel_6 = pix[6];

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for hires_artifact_color_renderer_core: directed rows and then
// random rows go in over the item channel, and each pixel beat is checked against a scan-row model.
// Depends on hacr_pkg for colour-class codes and on the core RTL.
`timescale 1ns / 1ps

module tb;
    import hacr_pkg::*;

    localparam int  RANDOM_ITEMS = 380;
    localparam int  CYCLE_LIMIT  = 200_000;
    localparam int  IDLE_PCT     = 13;
    localparam int  QUIET_FROM   = 150;
    localparam int  QUIET_TO     = 450;
    localparam int  DRAIN_CYCLES = 10;

    localparam logic [23:0] RGB_BLACK  = 24'h000000;
    localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
    localparam logic [23:0] RGB_PURPLE = 24'hD53EF9;
    localparam logic [23:0] RGB_GREEN  = 24'h64D440;
    localparam logic [23:0] RGB_BLUE   = 24'h458FF7;
    localparam logic [23:0] RGB_ORANGE = 24'hD7762C;

    typedef enum int {FILL_RANDOM, FILL_STRIPES, FILL_SPARSE, FILL_DENSE} fill_style_e;

    typedef struct packed {
        logic [7:0] video;
        logic       last;
    } feed_beat_t;

    typedef struct packed {
        logic [6:0][23:0] px;
        logic             done;
    } pixel_beat_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    logic [7:0]  video_byte   = 8'h00;
    logic        last_in_row  = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [23:0] pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5, pixel_6;
    logic        row_done;

    logic [6:0][23:0] got_px;
    assign got_px = {pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};

    feed_beat_t  byte_feed_q[$];
    pixel_beat_t due_pixels_q[$];

    // scan-row state of the model
    logic [6:0] row_left_px;
    logic [7:0] row_pend_byte;
    logic       row_pend_valid;
    logic       row_parity;

    int cycle_count     = 0;
    int error_count     = 0;
    int beats_taken     = 0;
    int results_checked = 0;
    int rows_closed     = 0;
    logic quiet;

    hires_artifact_color_renderer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .video_byte   (video_byte),
        .last_in_row  (last_in_row),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pixel_0      (pixel_0),
        .pixel_1      (pixel_1),
        .pixel_2      (pixel_2),
        .pixel_3      (pixel_3),
        .pixel_4      (pixel_4),
        .pixel_5      (pixel_5),
        .pixel_6      (pixel_6),
        .row_done     (row_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH result %0d %s: got %06h, want %06h",
                 results_checked, what, got, want);
        error_count++;
    endtask

    // seven pixels of one byte; the neighbourhood runs across the byte edges
    function automatic pixel_beat_t render_byte(input logic [6:0] left, input logic [7:0] cur,
                                                input logic [6:0] right, input logic parity,
                                                input logic done);
        pixel_beat_t beat;
        logic        l, c, r, j;
        logic [1:0]  cls;
        logic [23:0] col_a, col_b;
        col_a = cur[7] ? RGB_BLUE : RGB_PURPLE;
        col_b = cur[7] ? RGB_ORANGE : RGB_GREEN;
        for (int b = 0; b < 7; b++)
        begin
            l = (b == 0) ? left[6] : cur[b-1];
            c = cur[b];
            r = (b == 6) ? right[0] : cur[b+1];
            j = b[0] ^ parity;
            if (c)
                cls = (l || r) ? CI_WHITE : (j ? CI_B : CI_A);
            else
                cls = (l && r) ? (j ? CI_A : CI_B) : CI_BLACK;
            case (cls)
                CI_WHITE: beat.px[b] = RGB_WHITE;
                CI_A:     beat.px[b] = col_a;
                CI_B:     beat.px[b] = col_b;
                default:  beat.px[b] = RGB_BLACK;
            endcase
        end
        beat.done = done;
        return beat;
    endfunction

    // a pending byte goes out once its right neighbour arrives; a row-final byte at once
    task automatic advance_scan_row(input logic [7:0] video, input logic last);
        if (row_pend_valid)
        begin
            due_pixels_q.push_back(render_byte(row_left_px, row_pend_byte, video[6:0],
                                               row_parity, 1'b0));
            row_left_px = row_pend_byte[6:0];
            row_parity  = ~row_parity;
        end
        row_pend_byte  = video;
        row_pend_valid = 1'b1;
        if (last)
        begin
            due_pixels_q.push_back(render_byte(row_left_px, row_pend_byte, 7'h00,
                                               row_parity, 1'b1));
            row_left_px    = 7'h00;
            row_pend_byte  = 8'h00;
            row_pend_valid = 1'b0;
            row_parity     = 1'b0;
            rows_closed++;
        end
    endtask

    task automatic push_beat(input logic [7:0] video, input logic last);
        feed_beat_t fb;
        fb.video = video;
        fb.last  = last;
        byte_feed_q.push_back(fb);
    endtask

    // driver: predicts on each accepted beat, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            video_byte  <= 8'h00;
            last_in_row <= 1'b0;
        end
        else
        begin : drive_item
            feed_beat_t fb;
            if (item_valid && item_ready)
            begin
                advance_scan_row(video_byte, last_in_row);
                beats_taken++;
            end
            if (!item_valid || item_ready)
            begin
                if (byte_feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    fb = byte_feed_q.pop_front();
                    item_valid  <= 1'b1;
                    video_byte  <= fb.video;
                    last_in_row <= fb.last;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted pixel beat, stalls result_ready at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin : check_beat
            pixel_beat_t want;
            if (result_valid && result_ready)
            begin
                if (due_pixels_q.size() == 0)
                    report_mismatch("beat with nothing due, pixel_0", pixel_0, 24'h000000);
                else
                begin
                    want = due_pixels_q.pop_front();
                    for (int p = 0; p < 7; p++)
                        if (got_px[p] !== want.px[p])
                            report_mismatch($sformatf("pixel_%0d", p), got_px[p], want.px[p]);
                    if (row_done !== want.done)
                        report_mismatch("row_done", 24'(row_done), 24'(want.done));
                end
                results_checked++;
            end
            result_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_pixels_q.size());
            $display("hires_artifact_color_renderer_core regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          row_len;
        int          queued;
        fill_style_e style;
        logic [7:0]  b;

        row_left_px    = 7'h00;
        row_pend_byte  = 8'h00;
        row_pend_valid = 1'b0;
        row_parity     = 1'b0;

        // one-byte rows: zero neighbours both sides, both palettes
        push_beat(8'h7F, 1'b1);
        push_beat(8'h00, 1'b1);
        push_beat(8'hFF, 1'b1);
        push_beat(8'h80, 1'b1);
        // stripes give the single-pixel and gap colours at both parities
        push_beat(8'h55, 1'b0);
        push_beat(8'h2A, 1'b0);
        push_beat(8'hD5, 1'b0);
        push_beat(8'hAA, 1'b0);
        push_beat(8'h2A, 1'b0);
        push_beat(8'hD5, 1'b1);
        // lone pixels at the byte edges, neighbours across bytes
        push_beat(8'h01, 1'b0);
        push_beat(8'h40, 1'b0);
        push_beat(8'h81, 1'b0);
        push_beat(8'hC0, 1'b0);
        push_beat(8'h01, 1'b0);
        push_beat(8'h40, 1'b1);
        // gap of one across a byte edge
        push_beat(8'h20, 1'b0);
        push_beat(8'h01, 1'b1);
        // right neighbour on the last byte is taken as zero
        push_beat(8'hC0, 1'b1);

        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            row_len = ($urandom_range(9) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
            style   = fill_style_e'($urandom_range(3));
            for (int k = 0; k < row_len; k++)
            begin
                case (style)
                    FILL_STRIPES: b = {1'($urandom_range(1)), (k % 2) ? 7'h2A : 7'h55};
                    FILL_SPARSE:  b = {1'($urandom_range(1)), 7'(1 << $urandom_range(6))};
                    FILL_DENSE:   b = {1'($urandom_range(1)), ~7'(1 << $urandom_range(6))};
                    default:      b = 8'($urandom_range(255));
                endcase
                // flip the odd bit so patterned rows are not too regular
                if (style != FILL_RANDOM && $urandom_range(7) == 0)
                    b[$urandom_range(6)] ^= 1'b1;
                push_beat(b, k == row_len - 1);
                queued++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed_q.size() != 0 || item_valid)
            @(posedge clk);
        while (due_pixels_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d item beats over %0d rows, %0d pixel beats checked",
                 beats_taken, rows_closed, results_checked);
        $display("with random stalls on both channels and a stall-free stretch; %0d mismatches",
                 error_count);
        if (error_count == 0 && due_pixels_q.size() == 0)
            $display("hires_artifact_color_renderer_core regression: pass");
        else
            $display("hires_artifact_color_renderer_core regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hacr_pkg.sv
rtl/hacr_front.sv
rtl/hacr_queue.sv
rtl/hacr_render.sv
rtl/hires_artifact_color_renderer_core.sv
tb/tb.sv
